// ===== rtl/button_click_classifier_macros.svh =====
// ---------------------------------------------------------------------------
// Button click classifier assertion macros
// Shared assertion forms, clocked on i_clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bcc_pkg.sv =====
// ---------------------------------------------------------------------------
// Button click classifier package
// Shared widths, reset values, event codes and the level flag bundle.
// ---------------------------------------------------------------------------
package bcc_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_MS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_GAP_MS_RST = 16'd250;

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE_MS   = 2'd0,
        REG_LONG_PRESS_MS = 2'd1,
        REG_DOUBLE_GAP_MS = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_click_event;

    typedef struct packed {
        logic stable;
        logic prior;
        logic toggle;
        logic rise;
        logic fall;
    } t_level_flags;

endpackage

// ===== rtl/bcc_debounce.sv =====
// ---------------------------------------------------------------------------
// Button click classifier debounce stage
// Debounces the raw level and derives edge pulses and the toggle level.
// ---------------------------------------------------------------------------
`include "button_click_classifier_macros.svh"

module bcc_debounce
    import bcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_raw,
    input  logic [TIME_W-1:0] i_now,
    input  logic [CFG_W-1:0]  i_debounce_ms,
    output t_level_flags      o_flags
);

    logic [TIME_W-1:0] r_stamp;
    logic              r_last_raw;
    logic              r_stable;
    logic              r_toggle;

    logic [TIME_W-1:0] n_stamp;
    logic [TIME_W-1:0] w_diff;
    logic              n_stable;
    logic              n_toggle;
    logic              n_rise;
    logic              n_fall;

    always_comb begin
        n_stamp  = (i_raw != r_last_raw) ? i_now : r_stamp;
        w_diff   = i_now - n_stamp;
        n_stable = (w_diff > {{(TIME_W-CFG_W){1'b0}}, i_debounce_ms}) ? i_raw : r_stable;
        n_rise   = n_stable & ~r_stable;
        n_fall   = ~n_stable & r_stable;
        n_toggle = r_toggle ^ n_rise;

        o_flags.stable = n_stable;
        o_flags.prior  = r_stable;
        o_flags.toggle = n_toggle;
        o_flags.rise   = n_rise;
        o_flags.fall   = n_fall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp    <= '0;
            r_last_raw <= 1'b0;
            r_stable   <= 1'b0;
            r_toggle   <= 1'b0;
        end else if (i_en) begin
            r_stamp    <= n_stamp;
            r_last_raw <= i_raw;
            r_stable   <= n_stable;
            r_toggle   <= n_toggle;
        end
    end

    `BCC_ASSERT_NEXT(a_toggle_only_on_rise, !(i_en && n_rise), $stable(r_toggle), "toggle moved without a rising edge")
    `BCC_ASSERT_NEXT(a_stable_needs_steady_raw, i_en && (i_raw != r_last_raw), $stable(r_stable), "stable level moved on a raw change")

endmodule

// ===== rtl/bcc_click.sv =====
// ---------------------------------------------------------------------------
// Button click classifier click machine
// Classifies presses on the raw level into single, double and long events.
// ---------------------------------------------------------------------------
`include "button_click_classifier_macros.svh"

module bcc_click
    import bcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_raw,
    input  logic [TIME_W-1:0] i_now,
    input  logic [CFG_W-1:0]  i_debounce_ms,
    input  logic [CFG_W-1:0]  i_long_press_ms,
    input  logic [CFG_W-1:0]  i_double_gap_ms,
    output t_click_event      o_event
);

    typedef enum logic [1:0] {
        PH_IDLE         = 2'd0,
        PH_DOWN         = 2'd1,
        PH_WAIT_DOUBLE  = 2'd2,
        PH_WAIT_RELEASE = 2'd3
    } t_phase;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [TIME_W-1:0] r_stamp;
    logic [TIME_W-1:0] n_stamp;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_gt_debounce;
    logic              w_gt_long;
    logic              w_gt_gap;
    t_click_event      n_event;

    always_comb begin
        w_elapsed     = i_now - r_stamp;
        w_gt_debounce = w_elapsed > {{(TIME_W-CFG_W){1'b0}}, i_debounce_ms};
        w_gt_long     = w_elapsed > {{(TIME_W-CFG_W){1'b0}}, i_long_press_ms};
        w_gt_gap      = w_elapsed > {{(TIME_W-CFG_W){1'b0}}, i_double_gap_ms};
        n_phase       = r_phase;
        n_stamp       = r_stamp;
        n_event       = EV_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_raw) begin
                    n_phase = PH_DOWN;
                    n_stamp = i_now;
                end
            end
            PH_DOWN: begin
                priority if (i_raw && w_gt_long) begin
                    n_event = EV_LONG;
                    n_phase = PH_WAIT_RELEASE;
                end else if (!i_raw && w_gt_debounce) begin
                    n_phase = PH_WAIT_DOUBLE;
                    n_stamp = i_now;
                end
            end
            PH_WAIT_DOUBLE: begin
                priority if (w_gt_gap) begin
                    n_event = EV_SINGLE;
                    n_phase = PH_IDLE;
                end else if (i_raw && w_gt_debounce) begin
                    n_event = EV_DOUBLE;
                    n_phase = PH_WAIT_RELEASE;
                end
            end
            PH_WAIT_RELEASE: begin
                if (!i_raw && w_gt_debounce) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        o_event = n_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_stamp <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_stamp <= n_stamp;
        end
    end

    `BCC_ASSERT_IMPL(a_long_from_down, i_en && (n_event == EV_LONG), r_phase == PH_DOWN, "long press outside the down phase")
    `BCC_ASSERT_IMPL(a_double_from_wait, i_en && (n_event == EV_DOUBLE), r_phase == PH_WAIT_DOUBLE, "double click outside the gap phase")

endmodule

// ===== rtl/button_click_classifier.sv =====
// ---------------------------------------------------------------------------
// Button click classifier
// Debounces polled button samples and reports single, double and long clicks.
// ---------------------------------------------------------------------------
// Each input item is one poll (raw level and a wrapping millisecond time) and
// yields exactly one result item. The block takes one poll per clock unless the
// output stalls: a poll is captured in an input register, debounce and click
// work for it is done on the stored state, and the result is held in an output
// register. A waiting result does not stop the next poll being captured while
// the input register is empty. The user must write the three thresholds through
// the register port only while no poll is in flight; the block does not check.
`include "button_click_classifier_macros.svh"

module button_click_classifier
    import bcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [39:0]      s_axis_tdata,  // raw_level, now_ms[31:0], zero pad
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // stable_level, prior_level,
                                            // toggle_level, rise_pulse,
                                            // fall_pulse, click_event[1:0], pad
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0]  r_debounce_ms;
    logic [CFG_W-1:0]  r_long_press_ms;
    logic [CFG_W-1:0]  r_double_gap_ms;

    logic              r_in_valid;
    logic              r_in_raw;
    logic [TIME_W-1:0] r_in_now;
    logic              r_out_valid;
    t_level_flags      r_out_flags;
    t_click_event      r_out_event;

    logic              w_advance;
    logic              w_take;
    logic              w_fire;
    t_level_flags      w_flags;
    t_click_event      w_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_MS_RST;
            r_long_press_ms <= LONG_PRESS_MS_RST;
            r_double_gap_ms <= DOUBLE_GAP_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data;
                REG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data;
                REG_DOUBLE_GAP_MS: r_double_gap_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign w_fire        = r_in_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= w_take || (r_in_valid && !w_advance);
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_raw <= s_axis_tdata[0];
            r_in_now <= s_axis_tdata[TIME_W:1];
        end
        if (w_fire) begin
            r_out_flags <= w_flags;
            r_out_event <= w_event;
        end
    end

    bcc_debounce u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_fire),
        .i_raw         (r_in_raw),
        .i_now         (r_in_now),
        .i_debounce_ms (r_debounce_ms),
        .o_flags       (w_flags)
    );

    bcc_click u_click (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_fire),
        .i_raw           (r_in_raw),
        .i_now           (r_in_now),
        .i_debounce_ms   (r_debounce_ms),
        .i_long_press_ms (r_long_press_ms),
        .i_double_gap_ms (r_double_gap_ms),
        .o_event         (w_event)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_event, r_out_flags.fall, r_out_flags.rise,
                            r_out_flags.toggle, r_out_flags.prior, r_out_flags.stable};

    `BCC_ASSERT_NEXT(a_in_held_on_stall, r_in_valid && !w_advance, r_in_valid && $stable(r_in_now), "input item lost under stall")
    `BCC_ASSERT_IMPL(a_edge_exclusive, r_out_valid, !(r_out_flags.rise && r_out_flags.fall), "rise and fall in one item")

endmodule
